// ----- hw/rtl/fils_pkg.sv -----
package fils_pkg;

  // field widths of a request and a response
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;

  // default list depth and the cap on results of one find-all
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 16;
  localparam int unsigned MATCH_W        = $clog2(MAX_RESULTS + 1);

  // request operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 2'd0,
    MODE_FIND_FIRST = 2'd1,
    MODE_FIND_ALL   = 2'd2
  } mode_e;

  // scan controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

endpackage

// ----- hw/rtl/fils_req_if.sv -----
interface fils_req_if;
  import fils_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ----- hw/rtl/fils_rsp_if.sv -----
interface fils_rsp_if;
  import fils_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, output found, output position, output last, input ready);
  modport sink   (input valid, input found, input position, input last, output ready);
endinterface

// ----- hw/rtl/front_insert_list_with_value_search.sv -----
// insert: accepted only when idle, writes the memory on acceptance, gives no response
// find: accepted only when idle; reads up to entry_count entries, one per cycle
//   unless a response stalls, bound by the single registered memory read port;
//   find-first ends at its first match, find-all after MAX_RESULTS matches
// responses leave through an output register, one per cycle at most
// reset: asynchronous, active low; list empty and front slot zero, memory not cleared
module front_insert_list_with_value_search #(
  parameter int unsigned LIST_DEPTH = fils_pkg::LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fils_req_if.sink   req_i,
  fils_rsp_if.source rsp_o
);
  import fils_pkg::*;

  localparam int unsigned SLOT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PC_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // entry memory and its registered read port
  logic [VALUE_W-1:0] mem [LIST_DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  // control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] front_q, front_d;
  logic [PC_W-1:0]   rd_pos_q, rd_pos_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              pend_vld_q, pend_vld_d;
  logic [POS_W-1:0]  pend_pos_q, pend_pos_d;
  logic [MATCH_W-1:0] nmatch_q, nmatch_d;
  logic              out_vld_q;

  // payload registers
  logic [PC_W-1:0]    cmp_pos_q;
  logic [VALUE_W-1:0] key_q;
  logic               first_q;
  logic               out_found_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_last_q;

  // combinational controls
  logic             req_acc;
  logic             out_free;
  logic             hit;
  logic             issue;
  logic             stall;
  logic             rd_en;
  logic             wr_en;
  logic             load_req;
  logic             push;
  logic             push_found;
  logic [POS_W-1:0] push_pos;
  logic             push_last;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign hit      = cmp_vld_q && (rdata_q == key_q);
  assign issue    = rd_pos_q < PC_W'(cnt_q);

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;
  assign rsp_o.last     = out_last_q;

  // next state and datapath controls
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    front_d    = front_q;
    rd_pos_d   = rd_pos_q;
    rd_slot_d  = rd_slot_q;
    cmp_vld_d  = cmp_vld_q;
    pend_vld_d = pend_vld_q;
    pend_pos_d = pend_pos_q;
    nmatch_d   = nmatch_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_req   = 1'b0;
    stall      = 1'b0;
    push       = 1'b0;
    push_found = 1'b0;
    push_pos   = '0;
    push_last  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_i.mode)
            MODE_INSERT: begin
              wr_en = 1'b1;
              if (cnt_q != '0) begin
                front_d = (front_q == SLOT_W'(LIST_DEPTH - 1)) ? '0 : front_q + 1'b1;
              end
              if (cnt_q < CNT_W'(LIST_DEPTH)) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            MODE_FIND_FIRST, MODE_FIND_ALL: begin
              load_req   = 1'b1;
              state_d    = ST_SCAN;
              rd_pos_d   = '0;
              rd_slot_d  = front_q;
              cmp_vld_d  = 1'b0;
              pend_vld_d = 1'b0;
              nmatch_d   = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (hit && first_q) begin
          // first match ends a find-first request
          if (out_free) begin
            push       = 1'b1;
            push_found = 1'b1;
            push_pos   = cmp_pos_q[POS_W-1:0];
            push_last  = 1'b1;
            cmp_vld_d  = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            stall = 1'b1;
          end
        end else begin
          // a new match releases the held one, which is then known not to be last
          if (hit && pend_vld_q) begin
            if (out_free) begin
              push       = 1'b1;
              push_found = 1'b1;
              push_pos   = pend_pos_q;
            end else begin
              stall = 1'b1;
            end
          end
          if (!stall) begin
            if (hit) begin
              pend_vld_d = 1'b1;
              pend_pos_d = cmp_pos_q[POS_W-1:0];
              nmatch_d   = nmatch_q + 1'b1;
            end
            if ((hit && nmatch_q == MATCH_W'(MAX_RESULTS - 1)) || !issue) begin
              cmp_vld_d = 1'b0;
              state_d   = ST_FLUSH;
            end else begin
              rd_en     = 1'b1;
              cmp_vld_d = 1'b1;
              rd_pos_d  = rd_pos_q + 1'b1;
              rd_slot_d = (rd_slot_q == '0) ? SLOT_W'(LIST_DEPTH - 1) : rd_slot_q - 1'b1;
            end
          end
        end
      end

      ST_FLUSH: begin
        // final response: held match or a not-found marker
        if (out_free) begin
          push       = 1'b1;
          push_found = pend_vld_q;
          push_pos   = pend_vld_q ? pend_pos_q : '0;
          push_last  = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      front_q    <= '0;
      rd_pos_q   <= '0;
      rd_slot_q  <= '0;
      cmp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_pos_q <= '0;
      nmatch_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      front_q    <= front_d;
      rd_pos_q   <= rd_pos_d;
      rd_slot_q  <= rd_slot_d;
      cmp_vld_q  <= cmp_vld_d;
      pend_vld_q <= pend_vld_d;
      pend_pos_q <= pend_pos_d;
      nmatch_q   <= nmatch_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_req) begin
      key_q   <= req_i.value;
      first_q <= (req_i.mode == MODE_FIND_FIRST);
    end
    if (rd_en) begin
      cmp_pos_q <= rd_pos_q;
    end
    if (push) begin
      out_found_q <= push_found;
      out_pos_q   <= push_pos;
      out_last_q  <= push_last;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[front_d] <= req_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_slot_q];
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("memory read and write in the same cycle");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN))
    else $error("compare stage busy outside of a scan");

  a_miss_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_found_q) |-> (out_last_q && out_pos_q == '0))
    else $error("not-found response without last or with a position");

  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.mode == MODE_INSERT) |=> (cnt_q != '0))
    else $error("list empty after an insert");

endmodule
